// File: src/mwcrc_pkg.sv
// Package for the multi-width CRC engine.
// Holds the width codes, the register indexes and the register file struct.
// No dependencies.
package mwcrc_pkg;

   localparam int CRC_BITS  = 32;
   localparam int BYTE_BITS = 8;

   // width_mode codes; the unused code runs as a 32-bit CRC
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;

   // register indexes on the csr port
   localparam logic [1:0] CSR_WIDTH_MODE    = 2'd0;
   localparam logic [1:0] CSR_POLYNOMIAL    = 2'd1;
   localparam logic [1:0] CSR_INITIAL_VALUE = 2'd2;

   localparam logic [CRC_BITS-1:0] POLYNOMIAL_RESET    = 32'h04C1_1DB7;
   localparam logic [CRC_BITS-1:0] INITIAL_VALUE_RESET = 32'h0000_0000;

   typedef struct packed {
      logic [1:0]          width_mode;
      logic [CRC_BITS-1:0] polynomial;
      logic [CRC_BITS-1:0] initial_value;
   } csr_cfg_type;

endpackage

// File: src/mwcrc_csr.sv
// Configuration registers of the multi-width CRC engine.
// Depends on mwcrc_pkg for register indexes and the csr_cfg_type struct.
module mwcrc_csr
   import mwcrc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [CRC_BITS-1:0] csr_data,
   output csr_cfg_type         cfg
);

   csr_cfg_type cfg_ff;
   csr_cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH_MODE:    cfg_in.width_mode    = csr_data[1:0];
            CSR_POLYNOMIAL:    cfg_in.polynomial    = csr_data;
            CSR_INITIAL_VALUE: cfg_in.initial_value = csr_data;
            default:           cfg_in = cfg_ff;  // index beyond the list: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_mode    <= WIDTH_32;
         cfg_ff.polynomial    <= POLYNOMIAL_RESET;
         cfg_ff.initial_value <= INITIAL_VALUE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/mwcrc_core.sv
// Running CRC register and the unrolled eight-bit MSB-first update.
// Depends on mwcrc_pkg for width codes and csr_cfg_type.
module mwcrc_core
   import mwcrc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [BYTE_BITS-1:0] data_byte,
   input  logic                 first_byte,
   input  csr_cfg_type          cfg,
   output logic [CRC_BITS-1:0]  crc_next
);

   logic [CRC_BITS-1:0] crc_register_ff;
   logic [CRC_BITS-1:0] crc_register_in;
   logic [4:0]          align_shift;
   logic [CRC_BITS-1:0] start_value;
   logic [CRC_BITS-1:0] poly_aligned;
   logic [CRC_BITS-1:0] work;

   // narrow CRCs run left-aligned in the 32-bit datapath; the low bits stay zero
   always_comb begin
      case (cfg.width_mode)
         WIDTH_8:  align_shift = 5'd24;
         WIDTH_16: align_shift = 5'd16;
         default:  align_shift = 5'd0;
      endcase
   end

   always_comb begin
      start_value  = first_byte ? cfg.initial_value : crc_register_ff;
      poly_aligned = cfg.polynomial << align_shift;
      work         = (start_value << align_shift)
                     ^ {data_byte, {(CRC_BITS-BYTE_BITS){1'b0}}};
      for (int k = 0; k < BYTE_BITS; k++) begin
         if (work[CRC_BITS-1]) begin
            work = (work << 1) ^ poly_aligned;
         end else begin
            work = work << 1;
         end
      end
      crc_next        = work >> align_shift;
      crc_register_in = advance ? crc_next : crc_register_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_register_ff <= '0;
      end else begin
         crc_register_ff <= crc_register_in;
      end
   end

endmodule

// File: src/multi_width_crc_engine.sv
// Multi-width CRC engine: one byte per request, 8/16/32-bit MSB-first CRC.
// A request waits in the request register until the result register is empty or drained.
// Throughput: one request per cycle while rsp_stall is low; the whole byte update sits
// between the request register and the result register.
// Reset (synchronous): pipeline empty, CRC register zero, 32-bit mode,
// polynomial 0x04C11DB7, initial value zero.
module multi_width_crc_engine
   import mwcrc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_BITS-1:0] req_data_byte,
   input  logic                 req_first_byte,
   input  logic                 req_last_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CRC_BITS-1:0]  rsp_crc_value,
   output logic                 rsp_message_done,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [CRC_BITS-1:0]  csr_data
);

   csr_cfg_type          cfg;
   logic                 req_valid_ff, req_valid_in;
   logic [BYTE_BITS-1:0] req_byte_ff;
   logic                 req_first_ff;
   logic                 req_last_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CRC_BITS-1:0]  rsp_crc_ff;
   logic                 rsp_done_ff;
   logic [CRC_BITS-1:0]  crc_next;
   logic                 req_take;
   logic                 advance;

   mwcrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mwcrc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .data_byte  (req_byte_ff),
      .first_byte (req_first_ff),
      .cfg        (cfg),
      .crc_next   (crc_next)
   );

   // request moves on when the result register is empty or being drained
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_byte_ff  <= req_data_byte;
         req_first_ff <= req_first_byte;
         req_last_ff  <= req_last_byte;
      end
      if (advance) begin
         rsp_crc_ff  <= crc_next;
         rsp_done_ff <= req_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_crc_value    = rsp_crc_ff;
   assign rsp_message_done = rsp_done_ff;

endmodule

// File: tb/tb.sv
// Self-checking testbench for multi_width_crc_engine: directed table, then random byte streams.
// Needs mwcrc_pkg and the engine; expected CRCs come from a bitwise MSB-first predictor held here.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mwcrc_pkg::*;

   // width code left unused by the package; the engine runs it as 32-bit
   localparam logic [1:0] WIDTH_SPARE = 2'd3;

   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 150;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 8;

   typedef enum logic {ROW_SETTING, ROW_BYTE} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [7:0]          data;
      logic                first;
      logic                last;
      logic                fixed;     // crc below is the known answer
      logic [CRC_BITS-1:0] crc;
      logic [1:0]          width;
      logic [CRC_BITS-1:0] poly;
      logic [CRC_BITS-1:0] init;
   } plan_row_type;

   typedef struct packed {
      logic [CRC_BITS-1:0] crc;
      logic                done;
   } crc_result_type;

   localparam int PLAN_ROWS = 25;
   localparam plan_row_type DIRECTED_PLAN [0:PLAN_ROWS-1] = '{
      // out of reset, no first mark: register starts at zero
      '{ROW_BYTE,    8'h00, 1'b0, 1'b0, 1'b1, 32'h0000_0000, WIDTH_32, '0, '0},
      '{ROW_BYTE,    8'h01, 1'b1, 1'b1, 1'b1, 32'h04C1_1DB7, WIDTH_32, '0, '0},
      // carry on after a last mark
      '{ROW_BYTE,    8'hFF, 1'b0, 1'b0, 1'b0, 32'h0,         WIDTH_32, '0, '0},
      '{ROW_BYTE,    8'h80, 1'b0, 1'b1, 1'b0, 32'h0,         WIDTH_32, '0, '0},
      '{ROW_SETTING, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0,         WIDTH_8,  32'h07, 32'h0},
      '{ROW_BYTE,    8'h01, 1'b1, 1'b1, 1'b1, 32'h0000_0007, WIDTH_32, '0, '0},
      '{ROW_BYTE,    8'hFF, 1'b1, 1'b0, 1'b0, 32'h0,         WIDTH_32, '0, '0},
      '{ROW_BYTE,    8'h00, 1'b0, 1'b1, 1'b0, 32'h0,         WIDTH_32, '0, '0},
      '{ROW_SETTING, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0,         WIDTH_8,  32'h07, '1},
      '{ROW_BYTE,    8'hFF, 1'b1, 1'b1, 1'b1, 32'h0000_0000, WIDTH_32, '0, '0},
      '{ROW_SETTING, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0,         WIDTH_16, 32'h1021, '1},
      '{ROW_BYTE,    8'h00, 1'b1, 1'b0, 1'b0, 32'h0,         WIDTH_32, '0, '0},
      '{ROW_BYTE,    8'hA5, 1'b0, 1'b0, 1'b0, 32'h0,         WIDTH_32, '0, '0},
      // widen mid-message
      '{ROW_SETTING, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0,         WIDTH_32, 32'h1021, '1},
      '{ROW_BYTE,    8'h5A, 1'b0, 1'b1, 1'b0, 32'h0,         WIDTH_32, '0, '0},
      '{ROW_SETTING, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0,         WIDTH_SPARE, POLYNOMIAL_RESET, '1},
      '{ROW_BYTE,    8'h12, 1'b1, 1'b0, 1'b0, 32'h0,         WIDTH_32, '0, '0},
      '{ROW_BYTE,    8'h34, 1'b0, 1'b1, 1'b0, 32'h0,         WIDTH_32, '0, '0},
      // narrow after a last mark, with no first mark: stored register is cut to 8 bits
      '{ROW_SETTING, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0,         WIDTH_8,  POLYNOMIAL_RESET, '1},
      '{ROW_BYTE,    8'h56, 1'b0, 1'b1, 1'b0, 32'h0,         WIDTH_32, '0, '0},
      '{ROW_SETTING, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0,         WIDTH_32, '1, 32'hA5A5_5A5A},
      '{ROW_BYTE,    8'hFF, 1'b1, 1'b0, 1'b0, 32'h0,         WIDTH_32, '0, '0},
      '{ROW_BYTE,    8'h00, 1'b0, 1'b1, 1'b0, 32'h0,         WIDTH_32, '0, '0},
      // zero polynomial: the single set bit shifts straight out
      '{ROW_SETTING, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0,         WIDTH_32, '0, '0},
      '{ROW_BYTE,    8'h01, 1'b1, 1'b1, 1'b1, 32'h0000_0000, WIDTH_32, '0, '0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [BYTE_BITS-1:0] req_data_byte = '0;
   logic                 req_first_byte = 1'b0;
   logic                 req_last_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CRC_BITS-1:0]  rsp_crc_value;
   logic                 rsp_message_done;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [1:0]           csr_index = CSR_WIDTH_MODE;
   logic [CRC_BITS-1:0]  csr_data = '0;

   // predictor state and its copy of the registers
   logic [1:0]          cfg_width = WIDTH_32;
   logic [CRC_BITS-1:0] cfg_poly  = POLYNOMIAL_RESET;
   logic [CRC_BITS-1:0] cfg_init  = INITIAL_VALUE_RESET;
   logic [CRC_BITS-1:0] model_crc = '0;

   crc_result_type pending_crc_q [$];
   int             crc_mismatches = 0;
   bit             tx_idle_on = 1'b0;
   bit             rx_idle_on = 1'b0;
   bit             hold_request = 1'b0;

   multi_width_crc_engine i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_first_byte   (req_first_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_crc_value    (rsp_crc_value),
      .rsp_message_done (rsp_message_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #1 clock = ~clock;

   // MSB-first absorb of one byte at the configured width
   function automatic logic [CRC_BITS-1:0] next_crc(input logic [CRC_BITS-1:0] start,
                                                    input logic [7:0] data);
      logic [CRC_BITS-1:0] mask;
      logic [CRC_BITS-1:0] top;
      logic [CRC_BITS-1:0] poly;
      logic [CRC_BITS-1:0] crc_v;
      int unsigned         nbits;
      case (cfg_width)
         WIDTH_8:  nbits = 8;
         WIDTH_16: nbits = 16;
         default:  nbits = 32;
      endcase
      mask  = (nbits == 32) ? '1 : ((32'd1 << nbits) - 32'd1);
      top   = 32'd1 << (nbits - 1);
      poly  = cfg_poly & mask;
      crc_v = ((start & mask) ^ (32'(data) << (nbits - 8))) & mask;
      for (int k = 0; k < 8; k++) begin
         if ((crc_v & top) != 0) crc_v = ((crc_v << 1) ^ poly) & mask;
         else crc_v = (crc_v << 1) & mask;
      end
      return crc_v;
   endfunction

   // always lets at least one edge pass, so a following request is a fresh assignment
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_crc_q.size() != 0);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [CRC_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_setting(input logic [1:0] width, input logic [CRC_BITS-1:0] poly,
                                input logic [CRC_BITS-1:0] init);
      drain_results();
      csr_write(CSR_WIDTH_MODE, 32'(width));
      csr_write(CSR_POLYNOMIAL, poly);
      csr_write(CSR_INITIAL_VALUE, init);
      csr_valid <= 1'b0;
      cfg_width = width;
      cfg_poly  = poly;
      cfg_init  = init;
   endtask

   task automatic push_byte(input logic [7:0] data, input logic first, input logic last,
                            input logic fixed, input logic [CRC_BITS-1:0] fixed_crc);
      crc_result_type want;
      if (tx_idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_first_byte <= first;
      req_last_byte  <= last;
      do @(posedge clock); while (req_stall);
      model_crc = next_crc(first ? cfg_init : model_crc, data);
      want.crc  = fixed ? fixed_crc : model_crc;
      want.done = last;
      pending_crc_q.push_back(want);
   endtask

   // receiver: random stall bursts, plus one long hold on request from the sender
   initial begin
      int gap_left;
      bit hold_done;
      gap_left  = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            gap_left  = HOLD_CYCLES;
         end else if (gap_left == 0 && rx_idle_on && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 13);
         end
         if (gap_left > 0) begin
            rsp_stall <= 1'b1;
            gap_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      crc_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_crc_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual crc %h done %b",
                     $time, rsp_crc_value, rsp_message_done);
            crc_mismatches++;
         end else begin
            want = pending_crc_q.pop_front();
            if (rsp_crc_value !== want.crc) begin
               $display("%0t: crc_value mismatch: expected %h, actual %h",
                        $time, want.crc, rsp_crc_value);
               crc_mismatches++;
            end
            if (rsp_message_done !== want.done) begin
               $display("%0t: message_done mismatch: expected %b, actual %b",
                        $time, want.done, rsp_message_done);
               crc_mismatches++;
            end
         end
      end
   end

   initial begin
      int          msg_left;
      logic [7:0]  data_b;
      logic        first_b;
      logic        last_b;
      logic [1:0]  width_b;
      logic [31:0] poly_b;
      logic [31:0] init_b;
      msg_left = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      foreach (DIRECTED_PLAN[r]) begin
         if (DIRECTED_PLAN[r].kind == ROW_SETTING)
            apply_setting(DIRECTED_PLAN[r].width, DIRECTED_PLAN[r].poly, DIRECTED_PLAN[r].init);
         else
            push_byte(DIRECTED_PLAN[r].data, DIRECTED_PLAN[r].first, DIRECTED_PLAN[r].last,
                      DIRECTED_PLAN[r].fixed, DIRECTED_PLAN[r].crc);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         width_b = 2'($urandom_range(0, 3));
         case ($urandom_range(0, 5))
            0:       poly_b = '0;
            1:       poly_b = '1;
            2:       poly_b = POLYNOMIAL_RESET;
            default: poly_b = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0:       init_b = '0;
            1:       init_b = '1;
            default: init_b = $urandom;
         endcase
         // phase boundaries fall anywhere, so settings also change mid-message
         apply_setting(width_b, poly_b, init_b);
         tx_idle_on = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
         rx_idle_on = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 3 && n == 20) hold_request = 1'b1;
            if (phase == 5 && n == 40) drain_results();
            if (msg_left == 0) begin
               msg_left = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
               first_b = 1'b1;
            end else begin
               first_b = 1'b0;
            end
            last_b = (msg_left == 1);
            msg_left--;
            case ($urandom_range(0, 9))
               0:       data_b = 8'h00;
               1:       data_b = 8'hFF;
               default: data_b = 8'($urandom);
            endcase
            // occasional broken framing
            if ($urandom_range(0, 9) == 0) begin
               first_b = 1'($urandom);
               last_b  = 1'($urandom);
            end
            push_byte(data_b, first_b, last_b, 1'b0, '0);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (crc_mismatches == 0 && pending_crc_q.size() == 0)
         $display("multi_width_crc_engine verification clean");
      else
         $display("multi_width_crc_engine verification failed");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("multi_width_crc_engine verification failed");
      $finish;
   end

endmodule

// File: files.f
src/mwcrc_pkg.sv
src/mwcrc_csr.sv
src/mwcrc_core.sv
src/multi_width_crc_engine.sv
tb/tb.sv
